FILE: src/deoq_pkg.sv
// deoq_pkg: shared types and constants of the deadline-ordered event queue
// no dependencies; used by the interfaces, the queue cell and the top level

package deoq_pkg;

    localparam int unsigned TIME_W  = 64;
    localparam int unsigned DELAY_W = 32;
    localparam int unsigned TAG_W   = 16;

    // operation codes of an input word
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    // one queue entry as held by a cell
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] deadline;
        logic [TAG_W-1:0]  tag;
    } t_entry;

    // broadcast control from the top level to every cell
    typedef struct packed {
        logic              ins;
        logic              rem;
        logic              front;
        logic [TIME_W-1:0] deadline;
        logic [TAG_W-1:0]  tag;
    } t_cell_ctl;

endpackage

FILE: src/deoq_if.sv
// deoq_in_if / deoq_out_if: valid/ready channels of the event queue
// depends on deoq_pkg for field widths

interface deoq_in_if;
    import deoq_pkg::*;

    logic               valid;
    logic               ready;
    logic               operation;
    logic [TIME_W-1:0]  current_time;
    logic [DELAY_W-1:0] delay;
    logic [TAG_W-1:0]   event_tag;

    modport source (output valid, output operation, output current_time,
                    output delay, output event_tag, input ready);
    modport sink   (input valid, input operation, input current_time,
                    input delay, input event_tag, output ready);
endinterface

interface deoq_out_if;
    import deoq_pkg::*;

    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] inserted_deadline;
    logic              accepted;
    logic              head_valid;
    logic [TIME_W-1:0] head_deadline;
    logic [TAG_W-1:0]  head_tag;

    modport source (output valid, output inserted_deadline, output accepted,
                    output head_valid, output head_deadline, output head_tag,
                    input ready);
    modport sink   (input valid, input inserted_deadline, input accepted,
                    input head_valid, input head_deadline, input head_tag,
                    output ready);
endinterface

FILE: src/deadline_ordered_event_queue.sv
// deadline_ordered_event_queue: top level, sorted event queue on a row of cells
// depends on deoq_pkg, deoq_in_if / deoq_out_if and deoq_cell
//
// Usage: input words arrive on i_in (valid/ready). operation selects insert
// (deadline = current_time + delay, modulo 2^64, placed in ascending order,
// ties behind existing entries except at or before the head, where the new
// word goes in front) or remove (drop the head). Every input word gives one
// result word on o_out: the inserted deadline (zero for remove), accepted
// (zero for an insert into a full queue or a remove on an empty queue) and
// the head entry after the operation (zeros when the queue is empty).
// Each input word passes through the input stage and then the result register.
// Throughput: one word per cycle unless o_out stalls; the add is in the input
// stage and the cells then all compare and shift in parallel.
// Stall: while o_out.ready is low the result register holds, one more word
// waits in the input stage, then i_in.ready drops. Nothing is lost.
// Reset: i_rst_n (synchronous, active low) empties the queue and both stages;
// entry payloads are not cleared, only their valid bits.

module deadline_ordered_event_queue #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    deoq_in_if.sink     i_in,
    deoq_out_if.source  o_out
);
    import deoq_pkg::*;

    // input stage
    logic              r_busy;
    t_op               r_op;
    logic [TIME_W-1:0] r_deadline;
    logic [TAG_W-1:0]  r_tag;

    // result register
    logic              r_out_valid;
    logic [TIME_W-1:0] r_ins_deadline;
    logic              r_accepted;
    logic              r_head_valid;
    logic [TIME_W-1:0] r_head_deadline;
    logic [TAG_W-1:0]  r_head_tag;

    logic              w_adv;
    logic              w_full;
    logic              w_acc;
    t_cell_ctl         w_ctl;
    t_entry            w_cell [QUEUE_DEPTH];
    logic              w_flag [QUEUE_DEPTH];
    t_entry            w_head_next;

    // handshakes
    assign w_adv      = r_busy && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_busy || w_adv;

    // input stage: deadline add
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_busy <= 1'b1;
        end else if (w_adv) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_op       <= t_op'(i_in.operation);
            r_deadline <= i_in.current_time + TIME_W'(i_in.delay);
            r_tag      <= i_in.event_tag;
        end
    end

    // broadcast control to the cells
    assign w_full       = w_cell[QUEUE_DEPTH-1].valid;
    assign w_ctl.ins    = w_adv && (r_op == OP_INSERT) && !w_full;
    assign w_ctl.rem    = w_adv && (r_op == OP_REMOVE) && w_cell[0].valid;
    assign w_ctl.front  = w_cell[0].valid && (r_deadline <= w_cell[0].deadline);
    assign w_ctl.deadline = r_deadline;
    assign w_ctl.tag      = r_tag;

    // row of cells
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_left_flag;

        if (g == 0) begin : g_first
            assign w_left      = '{valid: 1'b1, deadline: '0, tag: '0};
            assign w_left_flag = 1'b0;
        end else begin : g_mid
            assign w_left      = w_cell[g-1];
            assign w_left_flag = w_flag[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_cell[g+1];
        end

        deoq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_left      (w_left),
            .i_left_flag (w_left_flag),
            .i_right     (w_right),
            .o_entry     (w_cell[g]),
            .o_flag      (w_flag[g])
        );
    end

    // head after the operation
    always_comb begin
        w_acc = 1'b0;
        w_head_next = w_cell[0];
        if (r_op == OP_INSERT) begin
            if (!w_full) begin
                w_acc = 1'b1;
                if (w_ctl.front || !w_cell[0].valid) begin
                    w_head_next = '{valid: 1'b1, deadline: r_deadline, tag: r_tag};
                end
            end
        end else if (w_cell[0].valid) begin
            w_acc = 1'b1;
            w_head_next = w_cell[1];
        end
        if (!w_head_next.valid) begin
            w_head_next = '0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ins_deadline  <= (r_op == OP_INSERT) ? r_deadline : '0;
            r_accepted      <= w_acc;
            r_head_valid    <= w_head_next.valid;
            r_head_deadline <= w_head_next.deadline;
            r_head_tag      <= w_head_next.tag;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.inserted_deadline = r_ins_deadline;
    assign o_out.accepted          = r_accepted;
    assign o_out.head_valid        = r_head_valid;
    assign o_out.head_deadline     = r_head_deadline;
    assign o_out.head_tag          = r_head_tag;

endmodule

FILE: src/deoq_cell.sv
// deoq_cell: one slot of the sorted shift-register queue
// depends on deoq_pkg (t_entry, t_cell_ctl)

module deoq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  deoq_pkg::t_cell_ctl i_ctl,
    input  deoq_pkg::t_entry   i_left,
    input  logic               i_left_flag,
    input  deoq_pkg::t_entry   i_right,
    output deoq_pkg::t_entry   o_entry,
    output logic               o_flag
);
    import deoq_pkg::*;

    logic              r_valid;
    logic [TIME_W-1:0] r_deadline;
    logic [TAG_W-1:0]  r_tag;
    logic              w_move;

    // this entry sits behind the new one: front insert or strictly later deadline
    assign o_flag = r_valid && (i_ctl.front || (i_ctl.deadline < r_deadline));

    // slot takes a word on insert when it shifts, or when it is the first free one
    assign w_move = o_flag || (!r_valid && i_left.valid);

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.rem) begin
            r_valid <= i_right.valid;
        end else if (i_ctl.ins && w_move) begin
            r_valid <= 1'b1;
        end
    end

    // payload: shift left on remove, take left neighbor or new word on insert
    always_ff @(posedge i_clk) begin
        if (i_ctl.rem) begin
            r_deadline <= i_right.deadline;
            r_tag      <= i_right.tag;
        end else if (i_ctl.ins && w_move) begin
            if (i_left_flag) begin
                r_deadline <= i_left.deadline;
                r_tag      <= i_left.tag;
            end else begin
                r_deadline <= i_ctl.deadline;
                r_tag      <= i_ctl.tag;
            end
        end
    end

    assign o_entry = '{valid: r_valid, deadline: r_deadline, tag: r_tag};

endmodule

FILE: bench/deoq_checker.sv
`timescale 1ns / 1ps
// deoq_checker: watches both channels of the deadline-ordered event queue,
// predicts every result word and compares it field by field
// depends on deoq_pkg and the deoq_in_if / deoq_out_if interfaces

module deoq_checker #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    deoq_in_if   i_req,
    deoq_out_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending
);
    import deoq_pkg::*;

    typedef struct packed {
        logic [TIME_W-1:0] inserted_deadline;
        logic              accepted;
        logic              head_valid;
        logic [TIME_W-1:0] head_deadline;
        logic [TAG_W-1:0]  head_tag;
    } t_queue_report;

    // predicted contents of the sorted queue, earliest deadline first
    logic [TIME_W-1:0] pend_deadline [QUEUE_DEPTH];
    logic [TAG_W-1:0]  pend_tag      [QUEUE_DEPTH];
    int unsigned       pend_count;

    t_queue_report due_reports [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        pend_count   = 0;
    end

    // ties go in front of the head, behind everything else
    function automatic void schedule_event(input logic [TIME_W-1:0] deadline,
                                           input logic [TAG_W-1:0] tag);
        int unsigned slot;
        slot = 0;
        if (pend_count > 0 && deadline > pend_deadline[0]) begin
            slot = 1;
            while (slot < pend_count && pend_deadline[slot] <= deadline)
                slot++;
        end
        for (int unsigned k = pend_count; k > slot; k--) begin
            pend_deadline[k] = pend_deadline[k-1];
            pend_tag[k]      = pend_tag[k-1];
        end
        pend_deadline[slot] = deadline;
        pend_tag[slot]      = tag;
        pend_count++;
    endfunction

    function automatic void retire_head();
        for (int unsigned k = 1; k < pend_count; k++) begin
            pend_deadline[k-1] = pend_deadline[k];
            pend_tag[k-1]      = pend_tag[k];
        end
        pend_count--;
    endfunction

    // apply one accepted input word and return the report it should produce
    function automatic t_queue_report predict_report(input t_op op,
                                                     input logic [TIME_W-1:0] now,
                                                     input logic [DELAY_W-1:0] dly,
                                                     input logic [TAG_W-1:0] tag);
        t_queue_report rep;
        rep = '0;
        if (op == OP_INSERT) begin
            rep.inserted_deadline = now + TIME_W'(dly);
            if (pend_count < QUEUE_DEPTH) begin
                schedule_event(rep.inserted_deadline, tag);
                rep.accepted = 1'b1;
            end
        end else if (pend_count > 0) begin
            retire_head();
            rep.accepted = 1'b1;
        end
        if (pend_count > 0) begin
            rep.head_valid    = 1'b1;
            rep.head_deadline = pend_deadline[0];
            rep.head_tag      = pend_tag[0];
        end
        return rep;
    endfunction

    task automatic check_field(input string field_name, input logic [TIME_W-1:0] want,
                               input logic [TIME_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $time, field_name, want, got);
            o_fail_count++;
        end
    endtask

    // predict on input words, compare on result words
    always @(posedge i_clk) begin
        t_queue_report want;
        if (!i_rst_n) begin
            pend_count = 0;
            due_reports.delete();
        end else begin
            if (i_req.valid && i_req.ready)
                due_reports.push_back(predict_report(t_op'(i_req.operation),
                                                     i_req.current_time,
                                                     i_req.delay, i_req.event_tag));
            if (i_rsp.valid && i_rsp.ready) begin
                if (due_reports.size() == 0) begin
                    $display("%0t: result word with nothing expected, actual deadline %h",
                             $time, i_rsp.inserted_deadline);
                    o_fail_count++;
                end else begin
                    want = due_reports.pop_front();
                    check_field("inserted_deadline", want.inserted_deadline,
                                i_rsp.inserted_deadline);
                    check_field("accepted", TIME_W'(want.accepted),
                                TIME_W'(i_rsp.accepted));
                    check_field("head_valid", TIME_W'(want.head_valid),
                                TIME_W'(i_rsp.head_valid));
                    check_field("head_deadline", want.head_deadline,
                                i_rsp.head_deadline);
                    check_field("head_tag", TIME_W'(want.head_tag),
                                TIME_W'(i_rsp.head_tag));
                end
            end
        end
        o_pending <= due_reports.size();
    end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// testbench: drives insert/remove words into the deadline-ordered event queue
// and gives the verdict; depends on deoq_pkg, the channel interfaces,
// deadline_ordered_event_queue and deoq_checker

module testbench;
    import deoq_pkg::*;

    localparam int unsigned QUEUE_DEPTH  = 16;
    localparam int          RANDOM_WORDS = 800;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          LIMIT_CYCLES = 200000;
    localparam int          IDLE_PCT     = 11;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count;

    // shared by both sides: no idling at all, and one long receiver hold-off
    logic calm;
    logic hold_off_req;

    deoq_in_if  in_ch ();
    deoq_out_if out_ch ();

    deadline_ordered_event_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    deoq_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (in_ch),
        .i_rsp       (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [TIME_W-1:0] rand_time();
        return {$urandom, $urandom};
    endfunction

    // offer one word, after random idle cycles unless calm, and wait for acceptance
    task automatic send_word(input t_op op, input logic [TIME_W-1:0] now,
                             input logic [DELAY_W-1:0] dly, input logic [TAG_W-1:0] tag);
        if (!calm) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_ch.valid        <= 1'b1;
        in_ch.operation    <= op;
        in_ch.current_time <= now;
        in_ch.delay        <= dly;
        in_ch.event_tag    <= tag;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
    endtask

    // receiver: random stalls, a calm stretch and one long hold-off
    initial begin
        int   hold_left;
        logic hold_done;
        hold_left    = 0;
        hold_done    = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req && !hold_done) begin
                hold_left = 90;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (calm) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // stimulus
    initial begin
        logic [TIME_W-1:0]  now;
        logic [TIME_W-1:0]  clock_now;
        logic [DELAY_W-1:0] dly;
        int unsigned        insert_pct;
        int unsigned        mix_pct [8];
        t_op                op;

        mix_pct            = '{75, 25, 90, 10, 50, 95, 5, 60};
        clock_now          = '0;
        calm               = 1'b0;
        hold_off_req       = 1'b0;
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.operation    = OP_INSERT;
        in_ch.current_time = '0;
        in_ch.delay        = '0;
        in_ch.event_tag    = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: remove on empty, extremes, wrap, ties, full queue
        send_word(OP_REMOVE, '0, '0, '0);
        send_word(OP_INSERT, 64'd0, 32'd0, 16'h0000);
        // wraps around to a small deadline
        send_word(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_word(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 16'h8001);
        // same deadline as the head goes in front of it
        send_word(OP_INSERT, 64'd0, 32'd0, 16'h1234);
        // same deadline as a later entry goes behind it
        send_word(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 16'hAAAA);
        for (int k = 0; k < 11; k++)
            send_word(OP_INSERT, TIME_W'($urandom_range(1000)),
                      DELAY_W'($urandom_range(1000)), TAG_W'($urandom_range(16'hFFFF)));
        // queue is full now, this one is rejected
        send_word(OP_INSERT, 64'd5, 32'd5, 16'h5555);
        repeat (3)
            send_word(OP_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);

        // random: insert share swings so the queue runs full and empty
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == 300)
                calm <= 1'b1;
            if (n == 420)
                calm <= 1'b0;
            if (n == 520)
                hold_off_req <= 1'b1;
            insert_pct = mix_pct[(n / 100) % 8];
            op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
            clock_now = clock_now + TIME_W'($urandom_range(20));
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: begin
                    // close deadlines, many ties
                    now = clock_now;
                    dly = DELAY_W'($urandom_range(40));
                end
                6, 7: begin
                    now = rand_time();
                    dly = $urandom;
                end
                8: begin
                    // near the top of the time range, usually wraps
                    now = 64'hFFFF_FFFF_FFFF_FFFF - TIME_W'($urandom_range(255));
                    dly = $urandom;
                end
                default: begin
                    now = clock_now;
                    dly = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
                end
            endcase
            send_word(op, now, dly, TAG_W'($urandom_range(16'hFFFF)));
        end
        in_ch.valid <= 1'b0;

        // let the last word reach the checker, then drain
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: deadline_ordered_event_queue.f
src/deoq_pkg.sv
src/deoq_if.sv
src/deoq_cell.sv
src/deadline_ordered_event_queue.sv
bench/deoq_checker.sv
bench/testbench.sv
